[hw/rtl/mandelbrot_escape_time_macros.svh]
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication.
`define MES_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MES_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mes_pkg.sv]
package mes_pkg;

	localparam int FRAC_BITS  = 56;
	localparam int WORD_W     = 64;
	localparam int WIDE_W     = 128;
	localparam int LIMB_W     = 32;
	localparam int COUNT_W    = 16;
	localparam int ZOOM_W     = 63;
	localparam int CFG_ADDR_W = 2;

	localparam logic [ZOOM_W-1:0]  ZOOM_RST      = 63'd769755248;
	localparam logic [WORD_W-1:0]  OFFSET_RE_RST = 64'd31532403150997265;
	localparam logic [WORD_W-1:0]  OFFSET_IM_RST = 64'd15168267660171906;
	localparam logic [COUNT_W-1:0] LIMIT_RST     = 16'd256;

	localparam logic [CFG_ADDR_W-1:0] CFG_ZOOM      = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_RE = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_IM = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT     = 2'd3;

	// Products, each named by its operands; the operation also picks the writeback.
	typedef enum logic [3:0] {
		OP_PZ_RE,
		OP_PZ_IM,
		OP_CI_SQ,
		OP_X_SQ,
		OP_Q_QX,
		OP_QTR_S,
		OP_ZR_ZI,
		OP_ZR_SQ,
		OP_ZI_SQ
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WAIT,
		ST_CARD,
		ST_CYCLE,
		ST_ESC
	} ctrl_state_t;

	typedef enum logic [1:0] {
		M_IDLE,
		M_PREP,
		M_MAC,
		M_FIN
	} mul_state_t;

	typedef struct packed {
		logic    load;
		logic    mul_start;
		logic    wb;
		mul_op_t op;
		logic    commit;
		logic    inc_iter;
		logic    finish;
		logic    escaped;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic in_cardioid;
		logic limit_zero;
		logic cycle_hit;
		logic escape;
		logic last_iter;
	} status_t;

	function automatic logic [WORD_W-1:0] sat64(input logic [WIDE_W-1:0] v);
		logic [WIDE_W-WORD_W:0] head;
		head = v[WIDE_W-1:WORD_W-1];
		if (head == '0 || head == '1)
			return v[WORD_W-1:0];
		else if (v[WIDE_W-1])
			return {1'b1, {(WORD_W-1){1'b0}}};
		else
			return {1'b0, {(WORD_W-1){1'b1}}};
	endfunction

endpackage

[hw/rtl/mes_mul.sv]
module mes_mul #(
	parameter int FRAC_BITS = mes_pkg::FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       wide,
	input  logic [mes_pkg::WIDE_W-1:0] a,
	input  logic [mes_pkg::WIDE_W-1:0] b,
	output logic                       done,
	output logic [mes_pkg::WIDE_W-1:0] res
);

	localparam int LW        = mes_pkg::LIMB_W;
	localparam int WW        = mes_pkg::WIDE_W;
	localparam int LIMBS     = WW / LW;
	localparam int IDX_W     = $clog2(LIMBS);
	localparam int ACC_LIMBS = 2 * LIMBS;
	localparam int ACC_IDX_W = $clog2(ACC_LIMBS);

	mes_pkg::mul_state_t state_q;

	logic [WW-1:0]                 a_q, b_q;
	logic [ACC_LIMBS-1:0][LW-1:0]  acc_q;
	logic [2*WW-1:0]               acc_flat;
	logic [LW-1:0]                 carry_q;
	logic [IDX_W-1:0]              i_q, j_q, last;
	logic                          neg_q, wide_q, done_q;
	logic [WW-1:0]                 res_q, prod, mag_a, mag_b;
	logic [ACC_IDX_W-1:0]          idx, idx_hi;
	logic [2*LW-1:0]               pp, t;

	assign last     = wide_q ? IDX_W'(LIMBS - 1) : IDX_W'(LIMBS / 2 - 1);
	assign idx      = ACC_IDX_W'(i_q) + ACC_IDX_W'(j_q);
	assign idx_hi   = idx + ACC_IDX_W'(1);
	assign pp       = a_q[i_q*LW +: LW] * b_q[j_q*LW +: LW];
	assign t        = pp + {{LW{1'b0}}, acc_q[idx]} + {{LW{1'b0}}, carry_q};
	assign acc_flat = acc_q;
	assign prod     = acc_flat[FRAC_BITS +: WW];
	assign mag_a    = a_q[WW-1] ? -a_q : a_q;
	assign mag_b    = b_q[WW-1] ? -b_q : b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mes_pkg::M_IDLE;
			done_q  <= 1'b0;
			wide_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				mes_pkg::M_IDLE: begin
					if (start) begin
						wide_q  <= wide;
						state_q <= mes_pkg::M_PREP;
					end
				end
				mes_pkg::M_PREP: begin
					i_q     <= '0;
					j_q     <= '0;
					state_q <= mes_pkg::M_MAC;
				end
				mes_pkg::M_MAC: begin
					if (j_q == last) begin
						j_q <= '0;
						i_q <= i_q + IDX_W'(1);
						if (i_q == last)
							state_q <= mes_pkg::M_FIN;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				mes_pkg::M_FIN: begin
					done_q  <= 1'b1;
					state_q <= mes_pkg::M_IDLE;
				end
				default: state_q <= mes_pkg::M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mes_pkg::M_IDLE: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
				end
			end
			mes_pkg::M_PREP: begin
				a_q     <= mag_a;
				b_q     <= mag_b;
				neg_q   <= a_q[WW-1] ^ b_q[WW-1];
				acc_q   <= '0;
				carry_q <= '0;
			end
			mes_pkg::M_MAC: begin
				acc_q[idx] <= t[LW-1:0];
				if (j_q == last) begin
					acc_q[idx_hi] <= t[2*LW-1:LW];
					carry_q       <= '0;
				end else begin
					carry_q <= t[2*LW-1:LW];
				end
			end
			mes_pkg::M_FIN: res_q <= neg_q ? -prod : prod;
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[hw/rtl/mes_datapath.sv]
module mes_datapath #(
	parameter int FRAC_BITS = mes_pkg::FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mes_pkg::cmd_t                      cmd,
	output mes_pkg::status_t                   st,
	input  logic signed [mes_pkg::WORD_W-1:0]  point_re,
	input  logic signed [mes_pkg::WORD_W-1:0]  point_im,
	input  logic [mes_pkg::ZOOM_W-1:0]         zoom,
	input  logic signed [mes_pkg::WORD_W-1:0]  offset_re,
	input  logic signed [mes_pkg::WORD_W-1:0]  offset_im,
	input  logic [mes_pkg::COUNT_W-1:0]        iteration_limit,
	output logic [mes_pkg::COUNT_W-1:0]        escape_count
);

	localparam int WD = mes_pkg::WORD_W;
	localparam int WW = mes_pkg::WIDE_W;
	localparam int CW = mes_pkg::COUNT_W;
	localparam logic [WW-1:0] QUARTER = WW'(1) << (FRAC_BITS - 2);
	localparam logic [WW-1:0] BOUND   = WW'(15) << FRAC_BITS;

	logic [WD-1:0] pt_re_q, pt_im_q, cr_q, ci_q;
	logic [WD-1:0] zr_q, zi_q, zn_re_q, zn_im_q;
	logic [WD-1:0] older_re_q, older_im_q, newer_re_q, newer_im_q;
	logic [WW-1:0] s_q, q_q, lhs_q, rhs_q, rr_q, ii_q;
	logic [CW-1:0] iter_q, count_q;

	logic [WW-1:0] x, mag, op_a, op_b, res;
	logic          op_wide, mul_done;

	function automatic logic [WW-1:0] sext(input logic [WD-1:0] v);
		return {{(WW-WD){v[WD-1]}}, v};
	endfunction

	assign x   = sext(cr_q) - QUARTER;
	assign mag = rr_q + ii_q;

	always_comb begin
		op_a    = '0;
		op_b    = '0;
		op_wide = 1'b0;
		case (cmd.op)
			mes_pkg::OP_PZ_RE: begin
				op_a = sext(pt_re_q);
				op_b = {{(WW-mes_pkg::ZOOM_W){1'b0}}, zoom};
			end
			mes_pkg::OP_PZ_IM: begin
				op_a = sext(pt_im_q);
				op_b = {{(WW-mes_pkg::ZOOM_W){1'b0}}, zoom};
			end
			mes_pkg::OP_CI_SQ: begin
				op_a = sext(ci_q);
				op_b = sext(ci_q);
			end
			mes_pkg::OP_X_SQ: begin
				op_a = x;
				op_b = x;
			end
			mes_pkg::OP_Q_QX: begin
				op_a    = q_q;
				op_b    = q_q + x;
				op_wide = 1'b1;
			end
			mes_pkg::OP_QTR_S: begin
				op_a    = QUARTER;
				op_b    = s_q;
				op_wide = 1'b1;
			end
			mes_pkg::OP_ZR_ZI: begin
				op_a = sext(zr_q);
				op_b = sext(zi_q);
			end
			mes_pkg::OP_ZR_SQ: begin
				op_a = sext(zr_q);
				op_b = sext(zr_q);
			end
			mes_pkg::OP_ZI_SQ: begin
				op_a = sext(zi_q);
				op_b = sext(zi_q);
			end
			default: ;
		endcase
	end

	mes_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.wide  (op_wide),
		.a     (op_a),
		.b     (op_b),
		.done  (mul_done),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.load) begin
			iter_q <= '0;
		end else if (cmd.inc_iter) begin
			iter_q <= iter_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pt_re_q    <= point_re;
			pt_im_q    <= point_im;
			zr_q       <= '0;
			zi_q       <= '0;
			older_re_q <= '0;
			older_im_q <= '0;
			newer_re_q <= '0;
			newer_im_q <= '0;
			rr_q       <= '0;
			ii_q       <= '0;
		end
		if (cmd.wb) begin
			case (cmd.op)
				mes_pkg::OP_PZ_RE: cr_q  <= mes_pkg::sat64(res + sext(offset_re));
				mes_pkg::OP_PZ_IM: ci_q  <= mes_pkg::sat64(res + sext(offset_im));
				mes_pkg::OP_CI_SQ: s_q   <= res;
				mes_pkg::OP_X_SQ:  q_q   <= res + s_q;
				mes_pkg::OP_Q_QX:  lhs_q <= res;
				mes_pkg::OP_QTR_S: rhs_q <= res;
				mes_pkg::OP_ZR_ZI: begin
					zn_re_q <= mes_pkg::sat64(rr_q - ii_q + sext(cr_q));
					zn_im_q <= mes_pkg::sat64(res + res + sext(ci_q));
				end
				mes_pkg::OP_ZR_SQ: rr_q <= res;
				mes_pkg::OP_ZI_SQ: ii_q <= res;
				default: ;
			endcase
		end
		if (cmd.commit) begin
			older_re_q <= newer_re_q;
			older_im_q <= newer_im_q;
			newer_re_q <= zn_re_q;
			newer_im_q <= zn_im_q;
			zr_q       <= zn_re_q;
			zi_q       <= zn_im_q;
		end
		if (cmd.finish)
			count_q <= cmd.escaped ? iter_q : '0;
	end

	always_comb begin
		st.mul_done    = mul_done;
		st.in_cardioid = $signed(lhs_q) < $signed(rhs_q);
		st.limit_zero  = iteration_limit == '0;
		st.cycle_hit   = (zn_re_q == older_re_q) && (zn_im_q == older_im_q);
		st.escape      = $signed(BOUND) < $signed(mag);
		st.last_iter   = iter_q == iteration_limit - CW'(1);
	end

	assign escape_count = count_q;

endmodule

[hw/rtl/mes_ctrl.sv]
module mes_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mes_pkg::status_t st,
	output mes_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	mes_pkg::ctrl_state_t state_q, state_n;
	mes_pkg::mul_op_t     op_q, op_n;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mes_pkg::ST_IDLE;
			op_q    <= mes_pkg::OP_PZ_RE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			op_q    <= op_n;
			done_q  <= cmd.finish;
		end
	end

	always_comb begin
		state_n = state_q;
		op_n    = op_q;
		cmd     = '0;
		cmd.op  = op_q;
		case (state_q)
			mes_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					op_n     = mes_pkg::OP_PZ_RE;
					state_n  = mes_pkg::ST_MUL;
				end
			end
			mes_pkg::ST_MUL: begin
				cmd.mul_start = 1'b1;
				state_n       = mes_pkg::ST_WAIT;
			end
			mes_pkg::ST_WAIT: begin
				if (st.mul_done) begin
					cmd.wb  = 1'b1;
					state_n = mes_pkg::ST_MUL;
					case (op_q)
						mes_pkg::OP_PZ_RE: op_n    = mes_pkg::OP_PZ_IM;
						mes_pkg::OP_PZ_IM: op_n    = mes_pkg::OP_CI_SQ;
						mes_pkg::OP_CI_SQ: op_n    = mes_pkg::OP_X_SQ;
						mes_pkg::OP_X_SQ:  op_n    = mes_pkg::OP_Q_QX;
						mes_pkg::OP_Q_QX:  op_n    = mes_pkg::OP_QTR_S;
						mes_pkg::OP_QTR_S: state_n = mes_pkg::ST_CARD;
						mes_pkg::OP_ZR_ZI: state_n = mes_pkg::ST_CYCLE;
						mes_pkg::OP_ZR_SQ: op_n    = mes_pkg::OP_ZI_SQ;
						mes_pkg::OP_ZI_SQ: state_n = mes_pkg::ST_ESC;
						default:           state_n = mes_pkg::ST_IDLE;
					endcase
				end
			end
			mes_pkg::ST_CARD: begin
				if (st.in_cardioid || st.limit_zero) begin
					cmd.finish = 1'b1;
					state_n    = mes_pkg::ST_IDLE;
				end else begin
					op_n    = mes_pkg::OP_ZR_ZI;
					state_n = mes_pkg::ST_MUL;
				end
			end
			mes_pkg::ST_CYCLE: begin
				if (st.cycle_hit) begin
					cmd.finish = 1'b1;
					state_n    = mes_pkg::ST_IDLE;
				end else begin
					cmd.commit = 1'b1;
					op_n       = mes_pkg::OP_ZR_SQ;
					state_n    = mes_pkg::ST_MUL;
				end
			end
			mes_pkg::ST_ESC: begin
				if (st.escape) begin
					cmd.finish  = 1'b1;
					cmd.escaped = 1'b1;
					state_n     = mes_pkg::ST_IDLE;
				end else if (st.last_iter) begin
					cmd.finish = 1'b1;
					state_n    = mes_pkg::ST_IDLE;
				end else begin
					cmd.inc_iter = 1'b1;
					op_n         = mes_pkg::OP_ZR_ZI;
					state_n      = mes_pkg::ST_MUL;
				end
			end
			default: state_n = mes_pkg::ST_IDLE;
		endcase
	end

	assign busy = state_q != mes_pkg::ST_IDLE;
	assign done = done_q;

endmodule

[hw/rtl/mandelbrot_escape_time.sv]
// Flow: done pulses once the cardioid test or a zero limit decides a point, or else after
// the z*z + c iterations that follow (an iteration that ends on a cycle skips both squares).
// All products share one 32x32 multiplier, one limb pair per cycle: 4 pairs for 64-bit
// operands, 16 for the two wide cardioid products. One point at a time; start is taken
// again in the cycle done is high. The receiver cannot stall.
// Reset: arst_n returns the controller to idle and loads the register reset values.
module mandelbrot_escape_time #(
	parameter int FRAC_BITS = mes_pkg::FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	output logic                                  done,
	input  logic signed [mes_pkg::WORD_W-1:0]     point_re,
	input  logic signed [mes_pkg::WORD_W-1:0]     point_im,
	output logic [mes_pkg::COUNT_W-1:0]           escape_count,
	input  logic                                  cfg_we,
	input  logic [mes_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [mes_pkg::WORD_W-1:0]            cfg_wdata
);

	logic [mes_pkg::ZOOM_W-1:0]         zoom_q;
	logic signed [mes_pkg::WORD_W-1:0]  offset_re_q, offset_im_q;
	logic [mes_pkg::COUNT_W-1:0]        limit_q;

	mes_pkg::cmd_t    cmd;
	mes_pkg::status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q      <= mes_pkg::ZOOM_RST;
			offset_re_q <= mes_pkg::OFFSET_RE_RST;
			offset_im_q <= mes_pkg::OFFSET_IM_RST;
			limit_q     <= mes_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				mes_pkg::CFG_ZOOM:      zoom_q      <= cfg_wdata[mes_pkg::ZOOM_W-1:0];
				mes_pkg::CFG_OFFSET_RE: offset_re_q <= cfg_wdata;
				mes_pkg::CFG_OFFSET_IM: offset_im_q <= cfg_wdata;
				mes_pkg::CFG_LIMIT:     limit_q     <= cfg_wdata[mes_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	mes_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.st    (st),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	mes_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.point_re       (point_re),
		.point_im       (point_im),
		.zoom           (zoom_q),
		.offset_re      (offset_re_q),
		.offset_im      (offset_im_q),
		.iteration_limit(limit_q),
		.escape_count   (escape_count)
	);

endmodule

[hw/rtl/mes_checker.sv]
`include "mandelbrot_escape_time_macros.svh"

module mes_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [mes_pkg::COUNT_W-1:0]  escape_count
);

	`MES_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`MES_ASSERT_NXT(a_done_single, done, !done, "done held longer than one cycle")
	`MES_ASSERT_IMP(a_done_idle, done, !busy, "done while still busy")
	`MES_ASSERT_IMP(a_busy_fall, $fell(busy), done, "busy dropped without a result")
	`MES_ASSERT_IMP(a_count_range, done, escape_count != '1, "escape count beyond the limit range")

endmodule

bind mandelbrot_escape_time mes_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.escape_count(escape_count)
);

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import mes_pkg::*;

	typedef logic signed [WIDE_W-1:0] acc_t;

	typedef struct {
		logic [WORD_W-1:0]  re;
		logic [WORD_W-1:0]  im;
		logic [COUNT_W-1:0] count;
	} point_txn_t;

	localparam logic [WORD_W-1:0] FX_ONE   = 64'd1 << FRAC_BITS;
	localparam logic [WORD_W-1:0] WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [WORD_W-1:0] WORD_MIN = 64'h8000_0000_0000_0000;
	localparam int WATCHDOG_LIMIT = 30000;
	localparam int DRAIN_CYCLES   = 200;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  done;
	logic [WORD_W-1:0]     point_re = '0;
	logic [WORD_W-1:0]     point_im = '0;
	logic [COUNT_W-1:0]    escape_count;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [WORD_W-1:0]     cfg_wdata = '0;

	// Register copies used for prediction
	logic [ZOOM_W-1:0]  view_zoom = ZOOM_RST;
	logic [WORD_W-1:0]  view_re   = OFFSET_RE_RST;
	logic [WORD_W-1:0]  view_im   = OFFSET_IM_RST;
	logic [COUNT_W-1:0] iter_limit = LIMIT_RST;

	point_txn_t         pending_points[$];
	logic [COUNT_W-1:0] expected_counts[$];
	logic [COUNT_W-1:0] presented_count = '0;
	int                 sender_idle_pct = 0;
	int                 phase_num = 0;
	int                 error_count = 0;
	int                 stall_cycles = 0;

	mandelbrot_escape_time u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.done         (done),
		.point_re     (point_re),
		.point_im     (point_im),
		.escape_count (escape_count),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic acc_t widen(input logic [WORD_W-1:0] v);
		return {{(WIDE_W-WORD_W){v[WORD_W-1]}}, v};
	endfunction

	function automatic logic [WORD_W-1:0] clamp64(input acc_t v);
		if (v[WIDE_W-1:WORD_W-1] == '0 || v[WIDE_W-1:WORD_W-1] == '1)
			return v[WORD_W-1:0];
		return v[WIDE_W-1] ? WORD_MIN : WORD_MAX;
	endfunction

	// Exact product, magnitude truncated by the fraction width, sign reapplied
	function automatic acc_t fx_mul(input acc_t a, input acc_t b);
		logic [WIDE_W-1:0]   ma;
		logic [WIDE_W-1:0]   mb;
		logic [2*WIDE_W-1:0] prod;
		acc_t                r;
		ma = a[WIDE_W-1] ? -a : a;
		mb = b[WIDE_W-1] ? -b : b;
		prod = {{WIDE_W{1'b0}}, ma} * {{WIDE_W{1'b0}}, mb};
		r = prod[FRAC_BITS +: WIDE_W];
		return (a[WIDE_W-1] ^ b[WIDE_W-1]) ? -r : r;
	endfunction

	function automatic logic [COUNT_W-1:0] predict_escape(input logic [WORD_W-1:0] re,
		input logic [WORD_W-1:0] im);
		acc_t               quarter;
		acc_t               bound;
		acc_t               x;
		acc_t               s;
		acc_t               q;
		acc_t               mag;
		logic [WORD_W-1:0]  c_re;
		logic [WORD_W-1:0]  c_im;
		logic [WORD_W-1:0]  z_re;
		logic [WORD_W-1:0]  z_im;
		logic [WORD_W-1:0]  nz_re;
		logic [WORD_W-1:0]  nz_im;
		logic [WORD_W-1:0]  old_re;
		logic [WORD_W-1:0]  old_im;
		logic [WORD_W-1:0]  new_re;
		logic [WORD_W-1:0]  new_im;
		logic [COUNT_W-1:0] count;
		c_re = clamp64(fx_mul(widen(re), {{(WIDE_W-ZOOM_W){1'b0}}, view_zoom}) + widen(view_re));
		c_im = clamp64(fx_mul(widen(im), {{(WIDE_W-ZOOM_W){1'b0}}, view_zoom}) + widen(view_im));
		quarter = 128'd1 << (FRAC_BITS - 2);
		bound = 128'd15 << FRAC_BITS;
		x = widen(c_re) - quarter;
		s = fx_mul(widen(c_im), widen(c_im));
		q = fx_mul(x, x) + s;
		if (fx_mul(q, q + x) < fx_mul(quarter, s))
			return '0;
		z_re = '0; z_im = '0;
		old_re = '0; old_im = '0;
		new_re = '0; new_im = '0;
		count = '0;
		for (int i = 0; i < iter_limit; i++) begin
			nz_re = clamp64(fx_mul(widen(z_re), widen(z_re)) - fx_mul(widen(z_im), widen(z_im))
				+ widen(c_re));
			nz_im = clamp64(fx_mul(widen(z_re), widen(z_im)) + fx_mul(widen(z_re), widen(z_im))
				+ widen(c_im));
			if (nz_re == old_re && nz_im == old_im)
				break;
			old_re = new_re; old_im = new_im;
			new_re = nz_re; new_im = nz_im;
			z_re = nz_re; z_im = nz_im;
			mag = fx_mul(widen(z_re), widen(z_re)) + fx_mul(widen(z_im), widen(z_im));
			if (mag > bound) begin
				count = i[COUNT_W-1:0];
				break;
			end
		end
		return count;
	endfunction

	function automatic logic [WORD_W-1:0] rand_signed(input int bits);
		logic signed [WORD_W-1:0] r;
		r = {$urandom, $urandom};
		r = r <<< (WORD_W - bits);
		r = r >>> (WORD_W - bits);
		return r;
	endfunction

	task automatic push_point(input logic [WORD_W-1:0] re, input logic [WORD_W-1:0] im);
		point_txn_t txn;
		txn.re = re;
		txn.im = im;
		txn.count = predict_escape(re, im);
		pending_points.push_back(txn);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (addr)
			CFG_ZOOM:      view_zoom = data[ZOOM_W-1:0];
			CFG_OFFSET_RE: view_re = data;
			CFG_OFFSET_IM: view_im = data;
			CFG_LIMIT:     iter_limit = data[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [WORD_W-1:0] zoom, input logic [WORD_W-1:0] ofs_re,
		input logic [WORD_W-1:0] ofs_im, input logic [WORD_W-1:0] limit);
		write_reg(CFG_ZOOM, zoom);
		write_reg(CFG_OFFSET_RE, ofs_re);
		write_reg(CFG_OFFSET_IM, ofs_im);
		write_reg(CFG_LIMIT, limit);
	endtask

	// Sender gaps rotate: none, heavy, none, moderate
	task automatic start_phase();
		case (phase_num % 4)
			1:       sender_idle_pct = 73;
			3:       sender_idle_pct = 35;
			default: sender_idle_pct = 0;
		endcase
		phase_num++;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_points.size() != 0 || start || expected_counts.size() != 0);
	endtask

	always @(posedge clk) begin : point_driver
		logic       holding;
		point_txn_t txn;
		if (arst_n) begin
			holding = start;
			if (start && !busy) begin
				expected_counts.push_back(presented_count);
				holding = 1'b0;
			end
			if (!holding && pending_points.size() != 0 &&
					$urandom_range(99) >= sender_idle_pct) begin
				txn = pending_points.pop_front();
				point_re <= txn.re;
				point_im <= txn.im;
				presented_count <= txn.count;
				holding = 1'b1;
			end
			start <= holding;
		end
	end

	always @(posedge clk) begin : result_monitor
		logic [COUNT_W-1:0] want;
		if (arst_n && done) begin
			if (expected_counts.size() == 0) begin
				$display("%0t: escape_count %0d with no transaction outstanding", $time,
					escape_count);
				error_count++;
			end else begin
				want = expected_counts.pop_front();
				if (escape_count !== want) begin
					$display("%0t: escape_count mismatch: expected %0d, actual %0d", $time,
						want, escape_count);
					error_count++;
				end
			end
		end
	end

	initial begin : watchdog
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [WORD_W-1:0] re_v;
		logic [WORD_W-1:0] im_v;
		logic [WORD_W-1:0] zoom_v;
		logic [WORD_W-1:0] ofs_re_v;
		logic [WORD_W-1:0] ofs_im_v;
		logic [WORD_W-1:0] limit_v;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset register values
		start_phase();
		repeat (20) push_point(rand_signed($urandom_range(40, 64)), rand_signed($urandom_range(40, 64)));
		wait_idle();

		// unit zoom, no offset: the point is c
		configure(FX_ONE, '0, '0, 64);
		start_phase();
		push_point('0, '0);
		push_point(-FX_ONE, '0);
		push_point(-(FX_ONE << 1), '0);
		push_point('0, FX_ONE);
		push_point('0, -FX_ONE);
		push_point(FX_ONE, '0);
		push_point(FX_ONE >> 2, '0);
		push_point(FX_ONE >> 1, '0);
		push_point(-FX_ONE - (FX_ONE >> 2), '0);
		push_point(-FX_ONE + (FX_ONE >> 2), FX_ONE >> 3);
		push_point(WORD_MAX, WORD_MAX);
		push_point(WORD_MIN, WORD_MIN);
		push_point(WORD_MAX, WORD_MIN);
		push_point(WORD_MIN, WORD_MAX);
		push_point('1, 64'd1);
		push_point('0, WORD_MAX);
		wait_idle();

		// zero iteration limit
		write_reg(CFG_LIMIT, '0);
		start_phase();
		push_point(FX_ONE, '0);
		push_point(WORD_MIN, WORD_MAX);
		wait_idle();

		// zoom top bit is dropped
		write_reg(CFG_ZOOM, 64'h8100_0000_0000_0000);
		write_reg(CFG_LIMIT, 64);
		start_phase();
		push_point(FX_ONE, '0);
		push_point('0, FX_ONE);
		wait_idle();

		// saturating c
		configure({1'b0, {(WORD_W-1){1'b1}}}, WORD_MAX, WORD_MIN, 1);
		start_phase();
		repeat (15) push_point({$urandom, $urandom}, {$urandom, $urandom});
		wait_idle();

		configure({1'b0, {(WORD_W-1){1'b1}}}, '0, '0, 20);
		start_phase();
		repeat (25) push_point(rand_signed($urandom_range(48, 52)), rand_signed($urandom_range(48, 52)));
		wait_idle();

		// maximum limit, points that settle early
		configure('0, FX_ONE, '0, 65535);
		start_phase();
		repeat (10) push_point({$urandom, $urandom}, {$urandom, $urandom});
		wait_idle();

		configure(FX_ONE, '0, '0, 65535);
		start_phase();
		repeat (40) begin
			case ($urandom_range(3))
				0: begin
					re_v = rand_signed(54);
					im_v = rand_signed(54);
				end
				1: begin
					re_v = (64'd5 << (FRAC_BITS - 1)) + ({$urandom, $urandom} >> 9);
					if ($urandom_range(1))
						re_v = -re_v;
					im_v = rand_signed(57);
				end
				2: begin
					case ($urandom_range(3))
						0:       begin re_v = -FX_ONE;        im_v = '0;      end
						1:       begin re_v = -(FX_ONE << 1); im_v = '0;      end
						2:       begin re_v = '0;             im_v = FX_ONE;  end
						default: begin re_v = '0;             im_v = -FX_ONE; end
					endcase
				end
				default: begin
					re_v = {$urandom, $urandom};
					re_v[WORD_W-2] = ~re_v[WORD_W-1];
					im_v = {$urandom, $urandom};
				end
			endcase
			push_point(re_v, im_v);
		end
		wait_idle();

		// default limit over the whole set
		configure(FX_ONE >> 1, -(FX_ONE >> 1), '0, 256);
		start_phase();
		repeat (30) push_point(rand_signed(59), rand_signed(59));
		wait_idle();

		repeat (14) begin
			zoom_v = ($urandom_range(3) == 0) ? {$urandom, $urandom}
				: ({$urandom, $urandom} >> $urandom_range(6, 10));
			ofs_re_v = ($urandom_range(3) == 0) ? {$urandom, $urandom} : rand_signed(58);
			ofs_im_v = ($urandom_range(3) == 0) ? {$urandom, $urandom} : rand_signed(58);
			limit_v = {$urandom, $urandom};
			limit_v[COUNT_W-1:0] = $urandom_range(1, 24);
			configure(zoom_v, ofs_re_v, ofs_im_v, limit_v);
			start_phase();
			repeat (100) begin
				if ($urandom_range(99) < 85) begin
					re_v = rand_signed($urandom_range(48, 58));
					im_v = rand_signed($urandom_range(48, 58));
				end else begin
					re_v = {$urandom, $urandom};
					im_v = {$urandom, $urandom};
				end
				push_point(re_v, im_v);
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[mandelbrot_escape_time.f]
+incdir+hw/rtl
hw/rtl/mes_pkg.sv
hw/rtl/mes_mul.sv
hw/rtl/mes_datapath.sv
hw/rtl/mes_ctrl.sv
hw/rtl/mandelbrot_escape_time.sv
hw/rtl/mes_checker.sv
test/testbench.sv
